// ----- rtl/hdr_tone_map_gamma_assert.svh -----
// Assertion macros for the tone mapping block.
`ifndef HDR_TONE_MAP_GAMMA_ASSERT_SVH
`define HDR_TONE_MAP_GAMMA_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define HTMG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("htmg assertion failed");
// Next-cycle implication.
`define HTMG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("htmg assertion failed");
`else
`define HTMG_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HTMG_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/htmg_pkg.sv -----
// Shared types and constants of the tone mapping block.
`default_nettype none
package htmg_pkg;

    localparam int CHAN_W = 24;
    localparam int EXP_W  = 16;
    localparam int OUT_W  = 16;
    localparam int LANES  = 3;

    typedef enum logic [1:0] {
        CURVE_NONE     = 2'd0,
        CURVE_REINHARD = 2'd1,
        CURVE_ACES     = 2'd2,
        CURVE_FILMIC   = 2'd3
    } t_curve;

    localparam logic REG_EXPOSURE   = 1'b0;
    localparam logic REG_TONE_CURVE = 1'b1;

    localparam logic [EXP_W-1:0]  EXPOSURE_RST   = 16'd256;
    localparam logic [CHAN_W-1:0] MAX_Q8_16      = 24'hFFFFFF;
    localparam logic [CHAN_W-1:0] FILMIC_WHITE_X = 24'd734004;

    localparam logic [31:0] ACES_NA = 32'd251;
    localparam logic [31:0] ACES_NB = 32'd196608;
    localparam logic [31:0] ACES_DA = 32'd243;
    localparam logic [31:0] ACES_DB = 32'd3866624;
    localparam logic [31:0] FILM_NA = 32'd210;
    localparam logic [31:0] FILM_NB = 32'd1638400;
    localparam logic [31:0] FILM_DA = 32'd15;
    localparam logic [31:0] FILM_DB = 32'd3276800;

    localparam logic [57:0] DEN_ONE   = 58'd65536;
    localparam logic [57:0] ACES_DC   = 58'd14 << 32;
    localparam logic [57:0] FILM_DC   = 58'd6 << 32;
    localparam logic [12:0] FILM_NSCL = 13'd6119;
    localparam logic [16:0] FILM_DSCL = 17'd66556;

    typedef struct packed {
        logic [63:0] num;
        logic [63:0] den;
    } t_frac;

endpackage
`default_nettype wire

// ----- rtl/htmg_in_if.sv -----
// Input pixel channel.
`default_nettype none
interface htmg_in_if;
    import htmg_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    modport source(output valid, red_in, green_in, blue_in, input ready);
    modport sink(input valid, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

// ----- rtl/htmg_out_if.sv -----
// Output pixel channel.
`default_nettype none
interface htmg_out_if;
    import htmg_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
    modport source(output valid, red_out, green_out, blue_out, input ready);
    modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface
`default_nettype wire

// ----- rtl/hdr_tone_map_gamma.sv -----
// Top level: HDR tone mapping with square-root gamma, one pixel per clock.
//
// Usage:
//   i_pix  carries one HDR pixel word (red_in, green_in, blue_in, unsigned Q8.16).
//   o_pix  carries one display pixel word (red_out, green_out, blue_out, Q0.16).
//   Both channels move a word on a clock edge with valid and ready high.
//   The config port writes exposure (index 0, Q8.8) or tone_curve (index 1)
//   when i_cfg_we is high; write it only while no pixel is in flight.
// Pipeline: from an accepted input word to its output word, 5 stages
//   exposure/curve, 8 stages divider, 4 stages square root.
// Throughput: one pixel per clock while the output is not stalled; the three color lanes run in lockstep.
//   The 16-step curve divider is spread over 8 stages, so it sets the depth.
// Reset: synchronous, active low; empties the pipeline, exposure becomes 1.0,
//   tone_curve becomes the ACES fit.
// Stall: when o_pix.ready is low with a word on the output, every stage
//   holds and i_pix.ready drops; no word is lost or repeated.
`default_nettype none
`include "hdr_tone_map_gamma_assert.svh"
module hdr_tone_map_gamma (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    htmg_in_if.sink          i_pix,
    htmg_out_if.source       o_pix,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import htmg_pkg::*;

    logic [EXP_W-1:0] r_exposure;
    t_curve           r_tone_curve;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exposure   <= EXPOSURE_RST;
            r_tone_curve <= CURVE_ACES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EXPOSURE:   r_exposure   <= i_cfg_data;
                REG_TONE_CURVE: r_tone_curve <= t_curve'(i_cfg_data[1:0]);
                default:        r_exposure   <= r_exposure;
            endcase
        end
    end

    // Advance all stages together unless the output word is stalled.
    logic w_en;
    assign w_en        = !o_pix.valid || o_pix.ready;
    assign i_pix.ready = w_en;

    logic [CHAN_W-1:0] w_chan      [LANES];
    logic [OUT_W-1:0]  w_y         [LANES];
    logic              w_cur_valid [LANES];
    logic              w_div_valid [LANES];
    logic              w_lane_valid[LANES];
    t_frac             w_frac      [LANES];
    logic [16:0]       w_t         [LANES];

    assign w_chan[0] = i_pix.red_in;
    assign w_chan[1] = i_pix.green_in;
    assign w_chan[2] = i_pix.blue_in;

    genvar l;
    for (l = 0; l < LANES; l++) begin : g_lane
        htmg_curve u_curve (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_en),
            .i_valid    (i_pix.valid),
            .i_chan     (w_chan[l]),
            .i_exposure (r_exposure),
            .i_curve    (r_tone_curve),
            .o_valid    (w_cur_valid[l]),
            .o_frac     (w_frac[l])
        );

        htmg_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cur_valid[l]),
            .i_frac  (w_frac[l]),
            .o_valid (w_div_valid[l]),
            .o_t     (w_t[l])
        );

        htmg_sqrt u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_div_valid[l]),
            .i_t     (w_t[l]),
            .o_valid (w_lane_valid[l]),
            .o_y     (w_y[l])
        );
    end

    // The last square-root stage is the output register.
    assign o_pix.valid     = w_lane_valid[0];
    assign o_pix.red_out   = w_y[0];
    assign o_pix.green_out = w_y[1];
    assign o_pix.blue_out  = w_y[2];

    logic w_lanes_agree;
    assign w_lanes_agree = (w_lane_valid[0] == w_lane_valid[1]) &&
                           (w_lane_valid[1] == w_lane_valid[2]) &&
                           (w_div_valid[0] == w_div_valid[2]);

    // lanes never drift apart
    `HTMG_ASSERT_IMP(a_lane_sync, i_clk, i_rst_n, 1'b1, w_lanes_agree)
    // a stall freezes the front end
    `HTMG_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(w_cur_valid[0]) && $stable(w_div_valid[0]))

endmodule
`default_nettype wire

// ----- rtl/htmg_curve.sv -----
// Exposure and curve front end: builds numerator and denominator of the curve.
`default_nettype none
module htmg_curve (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [23:0]           i_chan,
    input  wire logic [15:0]           i_exposure,
    input  wire htmg_pkg::t_curve      i_curve,
    output logic                       o_valid,
    output htmg_pkg::t_frac            o_frac
);
    import htmg_pkg::*;

    // stage 1: exposure product
    logic        r_v1;
    logic [39:0] r_p1;
    t_curve      r_c1;
    // stage 2: linear terms
    logic        r_v2;
    logic [23:0] r_x2;
    logic [31:0] r_ln2, r_ld2;
    t_curve      r_c2;
    logic        r_w2;
    // stage 3: quadratic terms
    logic        r_v3;
    logic [55:0] r_a3, r_b3;
    t_curve      r_c3;
    logic        r_w3;
    // stage 4: scaled partial products
    logic        r_v4;
    logic [44:0] r_nh4;
    logic [36:0] r_nl4;
    logic [50:0] r_dh4;
    logic [40:0] r_dl4;
    // stage 5
    logic        r_v5;
    t_frac       r_f5;

    logic [31:0] w_xw;
    logic [23:0] w_x;
    logic [31:0] w_x32;
    logic [31:0] n_ln, n_ld;
    logic        n_white;
    logic [57:0] w_cb, w_bf;
    logic [12:0] w_fn;
    logic [16:0] w_fd;

    always_comb begin
        w_xw    = r_p1[39:8];
        w_x     = (|w_xw[31:24]) ? MAX_Q8_16 : w_xw[23:0];
        w_x32   = {8'b0, w_x};
        n_white = 1'b0;
        case (r_c1)
            CURVE_NONE: begin
                n_ln = 32'd1;
                n_ld = 32'd0;
            end
            CURVE_REINHARD: begin
                n_ln = 32'd1;
                n_ld = 32'd1;
            end
            CURVE_ACES: begin
                n_ln = ACES_NA * w_x32 + ACES_NB;
                n_ld = ACES_DA * w_x32 + ACES_DB;
            end
            default: begin
                n_white = (w_x >= FILMIC_WHITE_X);
                n_ln    = n_white ? 32'd0 : FILM_NA * w_x32 + FILM_NB;
                n_ld    = n_white ? 32'd0 : FILM_DA * w_x32 + FILM_DB;
            end
        endcase
    end

    always_comb begin
        case (r_c3)
            CURVE_NONE:     w_cb = DEN_ONE;
            CURVE_REINHARD: w_cb = DEN_ONE;
            CURVE_ACES:     w_cb = ACES_DC;
            default:        w_cb = r_w3 ? 58'd0 : FILM_DC;
        endcase
        w_bf = {2'b0, r_b3} + w_cb;
        w_fn = (r_c3 == CURVE_FILMIC) ? FILM_NSCL : 13'd1;
        w_fd = (r_c3 == CURVE_FILMIC) ? FILM_DSCL : 17'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1  <= {16'b0, i_chan} * {24'b0, i_exposure};
            r_c1  <= i_curve;
            r_x2  <= w_x;
            r_ln2 <= n_ln;
            r_ld2 <= n_ld;
            r_c2  <= r_c1;
            r_w2  <= n_white;
            r_a3  <= {32'b0, r_x2} * {24'b0, r_ln2};
            r_b3  <= {32'b0, r_x2} * {24'b0, r_ld2};
            r_c3  <= r_c2;
            r_w3  <= r_w2;
            r_nh4 <= {13'b0, r_a3[55:24]} * {32'b0, w_fn};
            r_nl4 <= {13'b0, r_a3[23:0]} * {24'b0, w_fn};
            r_dh4 <= {17'b0, w_bf[57:24]} * {34'b0, w_fd};
            r_dl4 <= {17'b0, w_bf[23:0]} * {24'b0, w_fd};
            r_f5.num <= {r_nh4[39:0], 24'b0} + {27'b0, r_nl4};
            r_f5.den <= {r_dh4[39:0], 24'b0} + {23'b0, r_dl4};
        end
    end

    assign o_valid = r_v5;
    assign o_frac  = r_f5;

endmodule
`default_nettype wire

// ----- rtl/htmg_div.sv -----
// Pipelined restoring divider: 16 quotient bits, two per stage, saturating at 1.0.
`default_nettype none
module htmg_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire htmg_pkg::t_frac i_frac,
    output logic                 o_valid,
    output logic [16:0]          o_t
);
    import htmg_pkg::*;

    localparam int STAGES = 8;

    logic        r_v   [STAGES];
    logic [63:0] r_rem [STAGES];
    logic [63:0] r_den [STAGES];
    logic [15:0] r_q   [STAGES];
    logic        r_sat [STAGES];

    genvar g;
    for (g = 0; g < STAGES; g++) begin : g_stage
        logic        w_v;
        logic [63:0] w_rem, w_den;
        logic [15:0] w_q;
        logic        w_sat;
        logic [63:0] n_rem;
        logic [15:0] n_q;

        if (g == 0) begin : g_head
            assign w_v   = i_valid;
            assign w_rem = i_frac.num;
            assign w_den = i_frac.den;
            assign w_q   = 16'd0;
            assign w_sat = (i_frac.num >= i_frac.den);
        end else begin : g_body
            assign w_v   = r_v[g-1];
            assign w_rem = r_rem[g-1];
            assign w_den = r_den[g-1];
            assign w_q   = r_q[g-1];
            assign w_sat = r_sat[g-1];
        end

        always_comb begin
            n_rem = w_rem;
            n_q   = w_q;
            for (int k = 0; k < 2; k++) begin
                n_rem = {n_rem[62:0], 1'b0};
                if (n_rem >= w_den) begin
                    n_rem = n_rem - w_den;
                    n_q   = {n_q[14:0], 1'b1};
                end else begin
                    n_q   = {n_q[14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_den[g] <= w_den;
                r_q[g]   <= n_q;
                r_sat[g] <= w_sat;
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_t     = r_sat[STAGES-1] ? 17'h10000 : {1'b0, r_q[STAGES-1]};

endmodule
`default_nettype wire

// ----- rtl/htmg_sqrt.sv -----
// Pipelined integer square root of t * 65536, four result bits per stage.
`default_nettype none
module htmg_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [16:0] i_t,
    output logic             o_valid,
    output logic [15:0]      o_y
);
    import htmg_pkg::*;

    localparam int STAGES = 4;

    logic        r_v   [STAGES];
    logic [31:0] r_n   [STAGES];
    logic [31:0] r_res [STAGES];
    logic        r_sat [STAGES];

    genvar g;
    for (g = 0; g < STAGES; g++) begin : g_stage
        logic        w_v, w_sat;
        logic [31:0] w_n, w_res;
        logic [32:0] n_n, n_res, w_bit, w_sum;

        if (g == 0) begin : g_head
            assign w_v   = i_valid;
            assign w_n   = {i_t[15:0], 16'h0};
            assign w_res = 32'd0;
            assign w_sat = i_t[16];
        end else begin : g_body
            assign w_v   = r_v[g-1];
            assign w_n   = r_n[g-1];
            assign w_res = r_res[g-1];
            assign w_sat = r_sat[g-1];
        end

        always_comb begin
            n_n   = {1'b0, w_n};
            n_res = {1'b0, w_res};
            w_bit = 33'd0;
            w_sum = 33'd0;
            for (int k = 0; k < 4; k++) begin
                w_bit = 33'd1 << (30 - 8 * g - 2 * k);
                w_sum = n_res + w_bit;
                if (n_n >= w_sum) begin
                    n_n   = n_n - w_sum;
                    n_res = (n_res >> 1) + w_bit;
                end else begin
                    n_res = n_res >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g]   <= n_n[31:0];
                r_res[g] <= n_res[31:0];
                r_sat[g] <= w_sat;
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_y     = r_sat[STAGES-1] ? 16'hFFFF : r_res[STAGES-1][15:0];

endmodule
`default_nettype wire

// ----- verif/tb_hdr_tone_map_gamma.sv -----
// Testbench for the HDR tone mapping and gamma block: directed and random pixels, scoreboard check.
`default_nettype none
module tb_hdr_tone_map_gamma;
    import htmg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } t_hdr_px;

    typedef struct packed {
        logic [OUT_W-1:0] r;
        logic [OUT_W-1:0] g;
        logic [OUT_W-1:0] b;
    } t_disp_px;

    localparam int PIPE_DEPTH  = 17;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = REG_EXPOSURE;
    logic [15:0] i_cfg_data = '0;

    htmg_in_if  pix_in ();
    htmg_out_if pix_out ();

    hdr_tone_map_gamma i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_in.sink),
        .o_pix      (pix_out.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Predictor copy of the configuration registers.
    logic [EXP_W-1:0] gain_q8_8;
    t_curve           curve_sel;

    t_hdr_px  pending_px[$];
    t_disp_px expected_px[$];

    int  mismatches = 0;
    int  words_sent = 0;
    int  words_seen = 0;
    int  idle_cycles = 0;
    bit  idle_free = 1'b0;      // last part of the run: no idling
    bit  sender_hold = 1'b0;
    int  sink_hold_len = 0;     // long receiver hold, counted below

    // floor(num * 2^16 / den) saturated at 1.0 in Q.16
    function automatic logic [16:0] ratio_q16(logic [63:0] num, logic [63:0] den);
        logic [127:0] q;
        if (num >= den) return 17'd65536;
        q = ({64'd0, num} << 16) / den;
        return q[16:0];
    endfunction

    function automatic logic [OUT_W-1:0] map_chan(logic [CHAN_W-1:0] v);
        logic [63:0] x;
        logic [16:0] t;
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] root;
        x = (64'(v) * 64'(gain_q8_8)) >> 8;
        if (x > 64'(MAX_Q8_16)) x = 64'(MAX_Q8_16);
        case (curve_sel)
            CURVE_NONE:     t = (x > 64'd65536) ? 17'd65536 : x[16:0];
            CURVE_REINHARD: t = ratio_q16(x, x + 64'd65536);
            CURVE_ACES: begin
                n = x * (251 * x + 3 * 64'd65536);
                d = x * (243 * x + 59 * 64'd65536) + (64'd14 << 32);
                t = ratio_q16(n, d);
            end
            default: begin
                if (x >= 64'd734004) begin
                    t = 17'd65536;
                end else begin
                    n = 64'd6119 * (x * (210 * x + 25 * 64'd65536));
                    d = 64'd66556 * (x * (15 * x + 50 * 64'd65536) + (64'd6 << 32));
                    t = ratio_q16(n, d);
                end
            end
        endcase
        // Integer square root of t << 16 by bisection on the result bits.
        n = 64'(t) << 16;
        root = 0;
        for (int k = 16; k >= 0; k--) begin
            if ((root | (64'd1 << k)) * (root | (64'd1 << k)) <= n) root |= 64'd1 << k;
        end
        if (root > 64'd65535) root = 64'd65535;
        return root[OUT_W-1:0];
    endfunction

    function automatic t_disp_px tone_map_px(t_hdr_px p);
        t_disp_px o;
        o.r = map_chan(p.r);
        o.g = map_chan(p.g);
        o.b = map_chan(p.b);
        return o;
    endfunction

    int src_gap = 0;

    // Sample handshakes at the rising edge; update the offer at the falling edge.
    bit in_acc, out_acc;
    always @(posedge i_clk) begin
        in_acc  = i_rst_n && pix_in.valid && pix_in.ready;
        out_acc = i_rst_n && pix_out.valid && pix_out.ready;
        if (in_acc) begin
            expected_px = {expected_px,
                           tone_map_px({pix_in.red_in, pix_in.green_in, pix_in.blue_in})};
            words_sent++;
        end
        if (out_acc) begin
            t_disp_px got;
            t_disp_px want;
            got = {pix_out.red_out, pix_out.green_out, pix_out.blue_out};
            words_seen++;
            if (expected_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output word %h", got);
            end else begin
                want = expected_px.pop_front();
                if (got.r !== want.r || got.g !== want.g || got.b !== want.b) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected r=%h g=%h b=%h got r=%h g=%h b=%h",
                                 want.r, want.g, want.b, got.r, got.g, got.b);
                end
            end
        end
        // Watchdog: count cycles with no word moved while work remains.
        if (in_acc || out_acc || (pending_px.size() == 0 && expected_px.size() == 0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired: %0d pending, %0d expected",
                     pending_px.size(), expected_px.size());
            $display("status: fail");
            $finish;
        end
    end

    // Driver: drop the word taken at the last rising edge, then offer the
    // head of the pending queue; idle in random bursts.
    always @(negedge i_clk) begin
        t_hdr_px head;
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
        end else begin
            if (in_acc) void'(pending_px.pop_front());
            if (src_gap > 0) begin
                src_gap--;
                pix_in.valid <= 1'b0;
            end else if (!idle_free && !(pix_in.valid && !in_acc) &&
                         $urandom_range(0, 9) == 0) begin
                src_gap = $urandom_range(0, 2);
                pix_in.valid <= 1'b0;
            end else if (sender_hold) begin
                pix_in.valid <= 1'b0;
            end else begin
                if (pending_px.size() > 0) begin
                    head = pending_px[0];
                    pix_in.valid    <= 1'b1;
                    pix_in.red_in   <= head.r;
                    pix_in.green_in <= head.g;
                    pix_in.blue_in  <= head.b;
                end else begin
                    pix_in.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold on request.
    int sink_gap = 0;
    always @(negedge i_clk) begin
        if (sink_hold_len > 0) begin
            sink_hold_len--;
            pix_out.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            pix_out.ready <= 1'b0;
        end else if (!idle_free && $urandom_range(0, 9) == 0) begin
            sink_gap = $urandom_range(0, 2);
            pix_out.ready <= 1'b0;
        end else begin
            pix_out.ready <= 1'b1;
        end
    end

    initial begin
        pix_in.valid = 1'b0;
        pix_in.red_in = '0;
        pix_in.green_in = '0;
        pix_in.blue_in = '0;
        pix_out.ready = 1'b0;
    end

    // Wait until every queued word is through, then let the pipe drain.
    task automatic drain();
        while (pending_px.size() != 0 || expected_px.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_EXPOSURE) gain_q8_8 = val;
        else curve_sel = t_curve'(val[1:0]);
    endtask

    // Append one pixel to the pending queue.
    task automatic add_px(t_hdr_px p);
        pending_px = {pending_px, p};
    endtask

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return CHAN_W'($urandom_range(0, 255));
            1: return CHAN_W'($urandom_range(0, 131072));
            2: return CHAN_W'($urandom_range(0, 1048576));
            3: return CHAN_W'($urandom_range(700000, 770000));
            4: return MAX_Q8_16 - CHAN_W'($urandom_range(0, 255));
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    task automatic queue_random(int cnt);
        t_hdr_px p;
        repeat (cnt) begin
            p.r = rand_chan();
            p.g = rand_chan();
            p.b = rand_chan();
            add_px(p);
        end
    endtask

    // Settings visited by the random phases; the extremes are included.
    logic [15:0] gain_list[8] = '{16'd256, 16'd0, 16'hFFFF, 16'd1, 16'd128,
                                  16'd4096, 16'd700, 16'h8000};

    initial begin
        gain_q8_8 = EXPOSURE_RST;
        curve_sel = CURVE_ACES;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, white point edge, each curve at reset gain.
        for (int c = 0; c < 4; c++) begin
            if (c != 0) write_reg(REG_TONE_CURVE, 16'(c));
            else write_reg(REG_TONE_CURVE, 16'(CURVE_NONE));
            add_px({24'd0, 24'd65536, MAX_Q8_16});
            add_px({FILMIC_WHITE_X, FILMIC_WHITE_X - 24'd1, 24'd1});
            add_px({24'h555555, 24'hAAAAAA, 24'd65535});
            add_px({24'd65537, 24'd32768, 24'd734005});
            drain();
        end
        // Exposure overflow and zero gain.
        write_reg(REG_EXPOSURE, 16'hFFFF);
        add_px({MAX_Q8_16, 24'd300, 24'd70000});
        drain();
        write_reg(REG_EXPOSURE, 16'd0);
        add_px({MAX_Q8_16, 24'd300, 24'd70000});
        drain();

        // Random phases over curves and gains.
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(REG_TONE_CURVE, 16'(ph % 4));
            write_reg(REG_EXPOSURE, gain_list[ph / 2]);
            if (ph == 5) begin
                // long receiver hold while the sender keeps offering
                sink_hold_len = 200;
                queue_random(96);
            end else if (ph == 9) begin
                // sender pauses until all outstanding words are back
                queue_random(48);
                while (pending_px.size() != 0) @(posedge i_clk);
                sender_hold = 1'b1;
                while (expected_px.size() != 0) @(posedge i_clk);
                sender_hold = 1'b0;
                queue_random(48);
            end else begin
                if (ph >= 14) idle_free = 1'b1;
                queue_random(96);
            end
            drain();
        end

        $display("covered %0d pixels, all four curves, gains from 0 to 65535", words_sent);
        $display("included a long output hold and a sender pause; %0d words checked",
                 words_seen);
        if (mismatches == 0 && expected_px.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
